@@ rtl/core/deq_pkg.sv @@
// Shared types, request and status codes for the double-ended queue unit.
package deq_pkg;

    // Store geometry
    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    // Request codes
    typedef enum logic [3:0] {
        REQ_PUSH_FRONT = 4'd0,
        REQ_PUSH_BACK  = 4'd1,
        REQ_POP_FRONT  = 4'd2,
        REQ_POP_BACK   = 4'd3,
        REQ_CLEAR      = 4'd4,
        REQ_DELETE     = 4'd5,
        REQ_DUMP_ALL   = 4'd6,
        REQ_DUMP_FIRST = 4'd7,
        REQ_DUMP_LAST  = 4'd8
    } deq_req_e;

    // Result status codes
    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_EMPTY     = 2'd1,
        STS_FULL      = 2'd2,
        STS_NOT_FOUND = 2'd3
    } deq_status_e;

    // Request transfer payload
    typedef struct packed {
        logic [3:0]               req_type;
        logic signed [DATA_W-1:0] operand;
    } deq_req_t;

    // Result transfer payload
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     has_value;
        logic [1:0]               status;
        logic                     last;
    } deq_rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
        logic srch_init;
        logic dump_init;
        logic idx_inc;
        logic rd_next;
        logic shift_wr;
        logic del_done;
        logic emit_data;
        logic emit_status;
    } deq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [3:0] req_type;
        logic       dump_empty;
        logic       at_count;
        logic       match;
        logic       shift_end;
        logic       dump_last;
        logic       out_free;
    } deq_sts_t;

endpackage

@@ rtl/core/deq_ctrl.sv @@
// Sequencing state machine for the double-ended queue unit.
module deq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  deq_pkg::deq_sts_t sts,
    output deq_pkg::deq_cmd_t cmd
);
    import deq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIN,
        ST_DUMP_RD,
        ST_DUMP_OUT,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SHIFT_RD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   shift_wr_phase_reg;
    logic   shift_wr_phase_next;

    // Requests are taken only between commands
    assign req_stall = (state_reg != ST_IDLE);

    // Next state and command decode
    always_comb
    begin
        state_next          = state_reg;
        shift_wr_phase_next = 1'b0;
        cmd                 = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (sts.req_type)
                    REQ_DELETE:
                    begin
                        cmd.srch_init = 1'b1;
                        state_next    = ST_SRCH_RD;
                    end
                    REQ_DUMP_ALL, REQ_DUMP_FIRST, REQ_DUMP_LAST:
                    begin
                        cmd.dump_init = 1'b1;
                        state_next    = sts.dump_empty ? ST_FIN : ST_DUMP_RD;
                    end
                    default:
                    begin
                        cmd.exec   = 1'b1;
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_status = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_DUMP_RD:
            begin
                state_next = ST_DUMP_OUT;
            end
            ST_DUMP_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_data = 1'b1;
                    if (sts.dump_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_DUMP_RD;
                    end
                end
            end
            ST_SRCH_RD:
            begin
                state_next = sts.at_count ? ST_FIN : ST_SRCH_CMP;
            end
            ST_SRCH_CMP:
            begin
                if (sts.match)
                begin
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SRCH_RD;
                end
            end
            ST_SHIFT_RD:
            begin
                // Alternate: fetch the next entry, then write it one place down
                if (shift_wr_phase_reg)
                begin
                    cmd.shift_wr = 1'b1;
                    cmd.idx_inc  = 1'b1;
                end
                else if (sts.shift_end)
                begin
                    cmd.del_done = 1'b1;
                    state_next   = ST_FIN;
                end
                else
                begin
                    cmd.rd_next         = 1'b1;
                    shift_wr_phase_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            shift_wr_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            shift_wr_phase_reg <= shift_wr_phase_next;
        end
    end

endmodule

@@ rtl/core/deq_datapath.sv @@
// Circular store, pointers, scan index and result register of the deque unit.
module deq_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  deq_pkg::deq_req_t req_data,
    input  deq_pkg::deq_cmd_t cmd,
    output deq_pkg::deq_sts_t sts,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output deq_pkg::deq_rsp_t rsp_data
);
    import deq_pkg::*;

    // Front position plus logical offset, wrapped around the store
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                              input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(CAPACITY))
        begin
            sum = sum - (CNT_W + 1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    logic [DATA_W-1:0] mem [CAPACITY];

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [IDX_W-1:0]         head_reg;
    logic [IDX_W-1:0]         head_next;
    logic [3:0]               req_reg;
    logic signed [DATA_W-1:0] op_reg;
    logic [CNT_W-1:0]         idx_reg;
    logic [CNT_W-1:0]         idx_next;
    logic [CNT_W-1:0]         end_reg;
    logic [CNT_W-1:0]         end_next;
    logic [1:0]               status_reg;
    logic [1:0]               status_next;
    logic [DATA_W-1:0]        rd_data_reg;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    deq_rsp_t                 rsp_reg;
    deq_rsp_t                 rsp_next;

    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [DATA_W-1:0]        wr_data;
    logic [IDX_W-1:0]         rd_addr;
    logic [IDX_W-1:0]         head_dec;
    logic                     full;
    logic                     empty;
    logic [CNT_W-1:0]         clamp_k;
    logic [CNT_W-1:0]         dump_lo;
    logic [CNT_W-1:0]         dump_hi;
    logic [CNT_W:0]           idx_plus1;
    logic                     out_free;

    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign head_dec  = (head_reg == '0) ? IDX_W'(CAPACITY - 1) : head_reg - IDX_W'(1);
    assign idx_plus1 = (CNT_W + 1)'(idx_reg) + (CNT_W + 1)'(1);
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // Dump count clamped to 0..count
    always_comb
    begin
        if (op_reg[DATA_W-1])
        begin
            clamp_k = '0;
        end
        else if (DATA_W'(op_reg) > DATA_W'(count_reg))
        begin
            clamp_k = count_reg;
        end
        else
        begin
            clamp_k = op_reg[CNT_W-1:0];
        end
    end

    // Dump window [lo, hi)
    always_comb
    begin
        case (req_reg)
            REQ_DUMP_ALL:
            begin
                dump_lo = '0;
                dump_hi = count_reg;
            end
            REQ_DUMP_FIRST:
            begin
                dump_lo = '0;
                dump_hi = clamp_k;
            end
            REQ_DUMP_LAST:
            begin
                dump_lo = count_reg - clamp_k;
                dump_hi = count_reg;
            end
            default:
            begin
                dump_lo = '0;
                dump_hi = '0;
            end
        endcase
    end

    // Status toward the controller
    assign sts.req_type   = req_reg;
    assign sts.dump_empty = (dump_lo >= dump_hi);
    assign sts.at_count   = (idx_reg == count_reg);
    assign sts.match      = (rd_data_reg == DATA_W'(op_reg));
    assign sts.shift_end  = (idx_plus1 == (CNT_W + 1)'(count_reg));
    assign sts.dump_last  = (idx_plus1 == (CNT_W + 1)'(end_reg));
    assign sts.out_free   = out_free;

    // Read address: current entry, or the one after it while shifting
    assign rd_addr = phys(head_reg, cmd.rd_next ? idx_plus1[CNT_W-1:0] : idx_reg);

    // Store updates
    always_comb
    begin
        count_next  = count_reg;
        head_next   = head_reg;
        idx_next    = idx_reg;
        end_next    = end_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = phys(head_reg, count_reg);
        wr_data     = DATA_W'(op_reg);

        if (cmd.exec)
        begin
            status_next = STS_OK;
            case (req_reg)
                REQ_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = STS_FULL;
                    end
                    else
                    begin
                        head_next  = head_dec;
                        wr_en      = 1'b1;
                        wr_addr    = head_dec;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                REQ_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = STS_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                REQ_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = STS_EMPTY;
                    end
                    else
                    begin
                        head_next  = phys(head_reg, CNT_W'(1));
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                REQ_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = STS_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                REQ_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    status_next = STS_OK;
                end
            endcase
        end

        if (cmd.srch_init)
        begin
            idx_next    = '0;
            status_next = STS_NOT_FOUND;
        end

        if (cmd.dump_init)
        begin
            idx_next    = dump_lo;
            end_next    = dump_hi;
            status_next = STS_OK;
        end

        if (cmd.idx_inc)
        begin
            idx_next = idx_plus1[CNT_W-1:0];
        end

        // Move the fetched entry one place toward the front
        if (cmd.shift_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = phys(head_reg, idx_reg);
            wr_data = rd_data_reg;
        end

        if (cmd.del_done)
        begin
            count_next  = count_reg - CNT_W'(1);
            status_next = STS_OK;
        end
    end

    // Result register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (cmd.emit_data)
        begin
            rsp_valid_next     = 1'b1;
            rsp_next.value     = $signed(rd_data_reg);
            rsp_next.has_value = 1'b1;
            rsp_next.status    = STS_OK;
            rsp_next.last      = sts.dump_last;
        end
        else if (cmd.emit_status)
        begin
            rsp_valid_next     = 1'b1;
            rsp_next.value     = '0;
            rsp_next.has_value = 1'b0;
            rsp_next.status    = status_reg;
            rsp_next.last      = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            head_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            head_reg      <= head_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_data.req_type;
            op_reg  <= req_data.operand;
        end
        idx_reg    <= idx_next;
        end_reg    <= end_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    // Entry store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

`ifndef ASSERT_OFF
    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_data || cmd.emit_status) |-> out_free)
        else $error("result emitted while output register is occupied");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_wr |-> (idx_plus1 < (CNT_W + 1)'(count_reg)))
        else $error("shift write beyond stored entries");

    a_dump_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_data |-> ((idx_reg < end_reg) && (end_reg <= count_reg)))
        else $error("dump reads outside stored entries");
`endif

endmodule

@@ rtl/core/deque_with_delete_and_dump_unit.sv @@
// Top level of the bounded double-ended queue with delete and dump requests.
//
// Request channel (req_valid, req_stall, req_data) carries one command code and a
// 32-bit operand; response channel (rsp_valid, rsp_stall, rsp_data) returns results.
// Every request yields at least one result; the final one has last set. Dumps
// return one result per printed entry, front to back, with has_value set.
// Sequencing is paced by the single read port of the entry store, whose
// read data is registered:
//   push, pop, clear: the request is loaded, executed, then its result is
//     registered; the next request is taken once the sequencer is idle again.
//   dump: each entry is read, then emitted; an empty dump behaves like a push.
//   delete: entries are read and compared from the front until a match, then later ones shift down.
// One request is in work at a time; req_stall stays high until its last result
// is in the output register. A stalled result holds the output register, and
// the sequencer waits in place until rsp_stall drops.
// Reset empties the store at once (count and front pointer cleared); no
// clearing pass is needed since only stored positions are ever read.
module deque_with_delete_and_dump_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  deq_pkg::deq_req_t req_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output deq_pkg::deq_rsp_t rsp_data
);
    import deq_pkg::*;

    deq_cmd_t cmd;
    deq_sts_t sts;

    // Sequencer
    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Store and result path
    deq_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule
